### rtl/cbar_pkg.sv
// Shared types and codes of the CAN bus arbiter and router.
package cbar_pkg;

    localparam int ID_W     = 29;
    localparam int DLC_W    = 4;
    localparam int DATA_W   = 64;
    localparam int NID_W    = 8;
    localparam int STAT_W   = 3;
    localparam int REQ_W    = 2;
    localparam int PEND_W   = 5;
    localparam int CFG_A_W  = 3;
    localparam int CFG_SLOTS = 4;
    localparam int ACT_W    = 4;
    localparam logic [DLC_W-1:0] DLC_MAX = 4'd8;

    localparam logic [REQ_W-1:0] REQ_SUBMIT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STEP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RECV   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID  = 3'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN  = 3'd2;
    localparam logic [STAT_W-1:0] ST_TX_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_TX_EMPTY = 3'd4;
    localparam logic [STAT_W-1:0] ST_RX_BLOCK = 3'd5;
    localparam logic [STAT_W-1:0] ST_RX_EMPTY = 3'd6;

    localparam logic [CFG_A_W-1:0] CFG_ACTIVE = 3'd4;

    // one stored frame, identifier in the lowest bits
    typedef struct packed {
        logic [NID_W-1:0]  sender;
        logic [DATA_W-1:0] data;
        logic [DLC_W-1:0]  dlc;
        logic [ID_W-1:0]   id;
    } frame_t;

endpackage

### rtl/can_bus_arbiter_router_top.sv
// Virtual CAN hub: a pending table of submitted frames and one receive FIFO per node slot,
// both kept in single-port-read synchronous memories. Submit, receive and rejected items
// go from S_IDLE to S_FINISH, which registers the result once the output is free. A step
// scans the pending table one entry per cycle, checks the FIFOs (a full target FIFO ends it
// with ST_RX_BLOCK), visits one node slot per cycle to write each target FIFO, then closes
// the gap in the table one entry per cycle, as the table memory has a single read and
// write port. A new item is taken while the previous result still waits on the output.
module can_bus_arbiter_router_top
    import cbar_pkg::*;
#(
    parameter int NODES    = 4,
    parameter int TX_DEPTH = 16,
    parameter int RX_DEPTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // node_id[7:0], frame_id[36:8], frame_dlc[40:37], frame_data[104:41], zero fill
    input  logic [111:0]       s_tdata,
    // req_type
    input  logic [REQ_W-1:0]   s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // out_id[28:0], out_dlc[32:29], out_data[96:33], src_node[104:97],
    // tx_pending[109:105], zero fill
    output logic [111:0]       m_tdata,
    // status
    output logic [STAT_W-1:0]  m_tuser,
    input  logic               cfg_we,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [NID_W-1:0]   cfg_wdata
);

    localparam int IW  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int CW  = $clog2(TX_DEPTH + 1);
    localparam int PW  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int FW  = $clog2(RX_DEPTH + 1);
    localparam int DW  = $clog2(NODES);
    localparam int RAW = $clog2(NODES * RX_DEPTH);
    localparam int RXN = NODES * RX_DEPTH;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_DELIV  = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    // memories
    frame_t pend_mem [TX_DEPTH];
    frame_t rx_mem   [RXN];
    frame_t pend_rdata_reg;
    frame_t rx_rdata_reg;

    logic           pend_we, pend_re, rx_we, rx_re;
    logic [IW-1:0]  pend_waddr, pend_raddr;
    frame_t         pend_wdata;
    logic [RAW-1:0] rx_waddr, rx_raddr;

    // control and state
    logic [2:0]        state_reg, state_next;
    logic [NID_W-1:0]  node_id_reg [NODES];
    logic [NID_W-1:0]  node_id_next [NODES];
    logic [ACT_W-1:0]  active_reg, active_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [PW-1:0]     head_reg [NODES];
    logic [PW-1:0]     head_next [NODES];
    logic [FW-1:0]     fill_reg [NODES];
    logic [FW-1:0]     fill_next [NODES];
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]     cmp_idx_reg, cmp_idx_next;
    frame_t            best_reg, best_next;
    logic [IW-1:0]     best_idx_reg, best_idx_next;
    logic [DW-1:0]     ds_reg, ds_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;
    logic              res_pop_reg, res_pop_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [111:0]      m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0] m_tuser_reg, m_tuser_next;

    // decoded input
    logic [NID_W-1:0]  in_nid;
    frame_t            in_frame;
    logic [NODES-1:0]  slot_on;
    logic [NODES-1:0]  tgt;
    logic              hit;
    logic [DW-1:0]     hit_slot;
    logic              blocked;
    logic              accept;
    logic [FW:0]       wsum;
    logic [PW-1:0]     wptr;
    frame_t            pop_frame;

    assign in_nid          = s_tdata[7:0];
    assign in_frame.id     = s_tdata[36:8];
    assign in_frame.dlc    = s_tdata[40:37];
    assign in_frame.data   = s_tdata[104:41];
    assign in_frame.sender = s_tdata[7:0];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb
    begin
        slot_on  = '0;
        tgt      = '0;
        hit      = 1'b0;
        hit_slot = '0;
        blocked  = 1'b0;
        for (int s = NODES - 1; s >= 0; s--)
        begin
            slot_on[s] = (s < CFG_SLOTS) ? active_reg[s % CFG_SLOTS] : 1'b0;
            if (slot_on[s] && node_id_reg[s] == in_nid)
            begin
                hit      = 1'b1;
                hit_slot = DW'(s);
            end
            tgt[s] = slot_on[s] && (node_id_reg[s] != best_reg.sender);
            if (tgt[s] && fill_reg[s] == FW'(RX_DEPTH))
            begin
                blocked = 1'b1;
            end
        end
    end

    // write slot of the FIFO under delivery
    always_comb
    begin
        wsum = (FW + 1)'(head_reg[ds_reg]) + (FW + 1)'(fill_reg[ds_reg]);
        if (wsum >= (FW + 1)'(RX_DEPTH))
        begin
            wsum = wsum - (FW + 1)'(RX_DEPTH);
        end
        wptr = wsum[PW-1:0];
    end

    assign pop_frame = res_pop_reg ? rx_rdata_reg : '0;

    always_comb
    begin
        state_next    = state_reg;
        node_id_next  = node_id_reg;
        active_next   = active_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        ds_next       = ds_reg;
        res_stat_next = res_stat_reg;
        res_pop_next  = res_pop_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        pend_we       = 1'b0;
        pend_waddr    = '0;
        pend_wdata    = in_frame;
        pend_re       = 1'b0;
        pend_raddr    = '0;
        rx_we         = 1'b0;
        rx_waddr      = RAW'(ds_reg) * RAW'(RX_DEPTH) + RAW'(wptr);
        rx_re         = 1'b0;
        rx_raddr      = RAW'(hit_slot) * RAW'(RX_DEPTH) + RAW'(head_reg[hit_slot]);

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_we)
        begin
            for (int s = 0; s < NODES; s++)
            begin
                if (cfg_addr < CFG_A_W'(CFG_SLOTS) && cfg_addr == CFG_A_W'(s))
                begin
                    node_id_next[s] = cfg_wdata;
                end
                // a slot coming up starts with an empty FIFO
                if (cfg_addr == CFG_ACTIVE && s < CFG_SLOTS
                    && cfg_wdata[s % CFG_SLOTS] && !active_reg[s % CFG_SLOTS])
                begin
                    head_next[s] = '0;
                    fill_next[s] = '0;
                end
            end
            if (cfg_addr == CFG_ACTIVE)
            begin
                active_next = cfg_wdata[ACT_W-1:0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next    = S_FINISH;
                    res_stat_next = ST_OK;
                    res_pop_next  = 1'b0;
                    case (s_tuser)
                        REQ_SUBMIT:
                        begin
                            if (in_frame.dlc > DLC_MAX)
                            begin
                                res_stat_next = ST_INVALID;
                            end
                            else if (!hit)
                            begin
                                res_stat_next = ST_UNKNOWN;
                            end
                            else if (count_reg >= CW'(TX_DEPTH))
                            begin
                                res_stat_next = ST_TX_FULL;
                            end
                            else
                            begin
                                pend_we    = 1'b1;
                                pend_waddr = count_reg[IW-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_STEP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_stat_next = ST_TX_EMPTY;
                            end
                            else
                            begin
                                state_next  = S_SCAN;
                                rd_idx_next = '0;
                            end
                        end
                        REQ_RECV:
                        begin
                            if (!hit)
                            begin
                                res_stat_next = ST_UNKNOWN;
                            end
                            else if (fill_reg[hit_slot] == '0)
                            begin
                                res_stat_next = ST_RX_EMPTY;
                            end
                            else
                            begin
                                rx_re        = 1'b1;
                                res_pop_next = 1'b1;
                                head_next[hit_slot] =
                                    (head_reg[hit_slot] == PW'(RX_DEPTH - 1)) ? '0
                                    : head_reg[hit_slot] + 1'b1;
                                fill_next[hit_slot] = fill_reg[hit_slot] - 1'b1;
                            end
                        end
                        default:
                        begin
                            res_stat_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // one read per cycle, compare in the next cycle
                if (rd_idx_reg < count_reg)
                begin
                    pend_re      = 1'b1;
                    pend_raddr   = rd_idx_reg[IW-1:0];
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[IW-1:0];
                end
                if (cmp_vld_reg)
                begin
                    if (cmp_idx_reg == '0 || pend_rdata_reg.id < best_reg.id)
                    begin
                        best_next     = pend_rdata_reg;
                        best_idx_next = cmp_idx_reg;
                    end
                    if (CW'(cmp_idx_reg) + 1'b1 == count_reg)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (blocked)
                begin
                    res_stat_next = ST_RX_BLOCK;
                    state_next    = S_FINISH;
                end
                else
                begin
                    ds_next    = '0;
                    state_next = S_DELIV;
                end
            end
            S_DELIV:
            begin
                if (tgt[ds_reg])
                begin
                    rx_we             = 1'b1;
                    fill_next[ds_reg] = fill_reg[ds_reg] + 1'b1;
                end
                if (ds_reg == DW'(NODES - 1))
                begin
                    rd_idx_next = CW'(best_idx_reg) + 1'b1;
                    state_next  = S_SHIFT;
                end
                else
                begin
                    ds_next = ds_reg + 1'b1;
                end
            end
            S_SHIFT:
            begin
                // read entry i+1, write it to i on the next cycle
                if (rd_idx_reg < count_reg)
                begin
                    pend_re      = 1'b1;
                    pend_raddr   = rd_idx_reg[IW-1:0];
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = IW'(rd_idx_reg - 1'b1);
                end
                if (cmp_vld_reg)
                begin
                    pend_we    = 1'b1;
                    pend_waddr = cmp_idx_reg;
                    pend_wdata = pend_rdata_reg;
                end
                else if (rd_idx_reg >= count_reg)
                begin
                    count_next    = count_reg - 1'b1;
                    res_stat_next = ST_OK;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_stat_reg;
                    m_tdata_next  = {2'b00, PEND_W'(count_reg), pop_frame.sender,
                                     pop_frame.data, pop_frame.dlc, pop_frame.id};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            active_reg   <= '0;
            count_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int s = 0; s < NODES; s++)
            begin
                node_id_reg[s] <= '0;
                head_reg[s]    <= '0;
                fill_reg[s]    <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            node_id_reg  <= node_id_next;
            active_reg   <= active_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            cmp_vld_reg  <= cmp_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        ds_reg       <= ds_next;
        res_stat_reg <= res_stat_next;
        res_pop_reg  <= res_pop_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
        if (pend_re)
        begin
            pend_rdata_reg <= pend_mem[pend_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_waddr] <= '{sender: best_reg.sender, data: best_reg.data,
                                  dlc: best_reg.dlc, id: best_reg.id};
        end
        if (rx_re)
        begin
            rx_rdata_reg <= rx_mem[rx_raddr];
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TX_DEPTH))
        else $error("pending count beyond table depth");

    a_deliv_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DELIV && tgt[ds_reg]) |-> fill_reg[ds_reg] < FW'(RX_DEPTH))
        else $error("delivery into a full FIFO");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1))
        else $error("pending count jumped");

    a_shift_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && state_next == S_FINISH) |-> !pend_we)
        else $error("table shift ended with a write in flight");

endmodule
